>>> rtl/core/dftq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dftq_pkg;

  localparam int MAX_CELLS_DEF   = 32;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int COORD_W         = 32;
  localparam int INDEX_W         = 16;
  localparam int T_W             = 17;
  localparam int FRAC_SH         = 16;
  localparam logic [T_W-1:0] ONE_Q16 = 17'h10000;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELL     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_CELL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_X  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Z  = 3'd7;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [3:0] READ_LAST = 4'd8;
  localparam logic [3:0] LERP_LAST = 4'd6;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOC_D, ST_LOC_I, ST_LOC_F, ST_LOC_W, ST_ADDR, ST_READ, ST_LERP, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_WRITE, OP_CAPTURE, OP_LOC_D, OP_LOC_I, OP_LOC_F, OP_LOC_W,
    OP_ADDR, OP_READ, OP_LERP, OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] axis;
    logic [3:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic in_box;
  } status_t;

  // Operand and destination slots of the seven lerp steps.
  function automatic logic [2:0] lerp_a(input logic [2:0] step);
    case (step)
      3'd0: lerp_a = 3'd0;
      3'd1: lerp_a = 3'd3;
      3'd2: lerp_a = 3'd4;
      3'd3: lerp_a = 3'd7;
      3'd4: lerp_a = 3'd0;
      3'd5: lerp_a = 3'd2;
      default: lerp_a = 3'd0;
    endcase
  endfunction

  function automatic logic [2:0] lerp_b(input logic [2:0] step);
    case (step)
      3'd0: lerp_b = 3'd1;
      3'd1: lerp_b = 3'd2;
      3'd2: lerp_b = 3'd5;
      3'd3: lerp_b = 3'd6;
      3'd4: lerp_b = 3'd1;
      3'd5: lerp_b = 3'd3;
      default: lerp_b = 3'd1;
    endcase
  endfunction

  function automatic logic [2:0] lerp_dst(input logic [2:0] step);
    case (step)
      3'd0: lerp_dst = 3'd0;
      3'd1: lerp_dst = 3'd1;
      3'd2: lerp_dst = 3'd2;
      3'd3: lerp_dst = 3'd3;
      3'd4: lerp_dst = 3'd0;
      3'd5: lerp_dst = 3'd1;
      default: lerp_dst = 3'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/dftq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module dftq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           req_type,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire dftq_pkg::status_t status,
  output dftq_pkg::cmd_t      cmd
);

  dftq_pkg::state_t state, state_next;
  logic [1:0] axis, axis_next;
  logic [3:0] cnt, cnt_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dftq_pkg::ST_IDLE;
      axis      <= dftq_pkg::AXIS_X;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      axis      <= axis_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    axis_next  = axis;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    cmd.op     = dftq_pkg::OP_NONE;
    cmd.axis   = axis;
    cmd.cnt    = cnt;
    out_valid_next = out_valid && !out_ready;
    case (state)
      dftq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (req_type == dftq_pkg::REQ_QUERY) begin
            cmd.op     = dftq_pkg::OP_CAPTURE;
            axis_next  = dftq_pkg::AXIS_X;
            state_next = dftq_pkg::ST_LOC_D;
          end else begin
            cmd.op = dftq_pkg::OP_WRITE;
          end
        end
      end
      dftq_pkg::ST_LOC_D: begin
        cmd.op     = dftq_pkg::OP_LOC_D;
        state_next = dftq_pkg::ST_LOC_I;
      end
      dftq_pkg::ST_LOC_I: begin
        cmd.op     = dftq_pkg::OP_LOC_I;
        state_next = dftq_pkg::ST_LOC_F;
      end
      dftq_pkg::ST_LOC_F: begin
        cmd.op     = dftq_pkg::OP_LOC_F;
        state_next = dftq_pkg::ST_LOC_W;
      end
      dftq_pkg::ST_LOC_W: begin
        cmd.op = dftq_pkg::OP_LOC_W;
        if (axis == dftq_pkg::AXIS_Z) begin
          state_next = dftq_pkg::ST_ADDR;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = dftq_pkg::ST_LOC_D;
        end
      end
      dftq_pkg::ST_ADDR: begin
        cmd.op     = dftq_pkg::OP_ADDR;
        cnt_next   = '0;
        state_next = status.in_box ? dftq_pkg::ST_READ : dftq_pkg::ST_DONE;
      end
      dftq_pkg::ST_READ: begin
        cmd.op = dftq_pkg::OP_READ;
        if (cnt == dftq_pkg::READ_LAST) begin
          cnt_next   = '0;
          state_next = dftq_pkg::ST_LERP;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      dftq_pkg::ST_LERP: begin
        cmd.op = dftq_pkg::OP_LERP;
        if (cnt == dftq_pkg::LERP_LAST) begin
          state_next = dftq_pkg::ST_DONE;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      dftq_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.op         = dftq_pkg::OP_OUT;
          out_valid_next = 1'b1;
          state_next     = dftq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dftq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/dftq_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module dftq_dp #(
  parameter int MAX_CELLS   = dftq_pkg::MAX_CELLS_DEF,
  parameter int VALUE_WIDTH = dftq_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire dftq_pkg::cmd_t                        cmd,
  output dftq_pkg::status_t                          status,
  input  wire logic                                  cfg_we,
  input  wire logic [dftq_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [dftq_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire logic [dftq_pkg::INDEX_W-1:0]          vertex_index,
  input  wire logic signed [VALUE_WIDTH-1:0]         vertex_distance,
  input  wire logic signed [VALUE_WIDTH-1:0]         vertex_cp_x,
  input  wire logic signed [VALUE_WIDTH-1:0]         vertex_cp_y,
  input  wire logic signed [VALUE_WIDTH-1:0]         vertex_cp_z,
  input  wire logic signed [dftq_pkg::COORD_W-1:0]   query_x,
  input  wire logic signed [dftq_pkg::COORD_W-1:0]   query_y,
  input  wire logic signed [dftq_pkg::COORD_W-1:0]   query_z,
  output logic                                       inside_res,
  output logic signed [VALUE_WIDTH-1:0]              distance_out,
  output logic signed [VALUE_WIDTH-1:0]              cp_out_x,
  output logic signed [VALUE_WIDTH-1:0]              cp_out_y,
  output logic signed [VALUE_WIDTH-1:0]              cp_out_z
);

  localparam int VW    = VALUE_WIDTH;
  localparam int DEPTH = (MAX_CELLS + 1) * (MAX_CELLS + 1) * (MAX_CELLS + 1);
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_CELLS + 1);
  localparam int IW    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int TOPW  = CW + 31;
  localparam int FW    = 41;
  localparam int PW    = VW + 18;

  // Configuration registers.
  logic signed [31:0] org_x, org_y, org_z;
  logic [30:0] cs, inv;
  logic [5:0]  ncx, ncy, ncz;

  always_ff @(posedge clk) begin
    if (rst) begin
      org_x <= '0;
      org_y <= '0;
      org_z <= '0;
      cs    <= 31'd65536;
      inv   <= 31'd65536;
      ncx   <= 6'd32;
      ncy   <= 6'd32;
      ncz   <= 6'd32;
    end else if (cfg_we) begin
      case (cfg_index)
        dftq_pkg::REG_ORIGIN_X: org_x <= cfg_data;
        dftq_pkg::REG_ORIGIN_Y: org_y <= cfg_data;
        dftq_pkg::REG_ORIGIN_Z: org_z <= cfg_data;
        dftq_pkg::REG_CELL:     cs    <= cfg_data[30:0];
        dftq_pkg::REG_INV_CELL: inv   <= cfg_data[30:0];
        dftq_pkg::REG_CELLS_X:  ncx   <= cfg_data[5:0];
        dftq_pkg::REG_CELLS_Y:  ncy   <= cfg_data[5:0];
        dftq_pkg::REG_CELLS_Z:  ncz   <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  function automatic logic [CW-1:0] cells_eff(input logic [5:0] raw);
    if (raw == 6'd0) cells_eff = CW'(1);
    else if (32'(raw) > MAX_CELLS) cells_eff = CW'(MAX_CELLS);
    else cells_eff = CW'(raw);
  endfunction

  logic [CW-1:0] nx, ny, nz;
  assign nx = cells_eff(ncx);
  assign ny = cells_eff(ncy);
  assign nz = cells_eff(ncz);

  // Captured query and per-axis locate pipeline.
  logic signed [31:0] qx, qy, qz;
  logic signed [31:0] q_sel, org_sel;
  logic [CW-1:0]      n_sel;
  logic signed [32:0] d;
  logic [TOPW-1:0]    top;
  logic [30:0]        i_raw;
  logic               ax_out;
  logic signed [FW-1:0] frac;
  logic [IW-1:0]      ix, iy, iz, i_cl;
  logic [dftq_pkg::T_W-1:0] tx, ty, tz, t_new;
  logic               inside_acc;
  logic [AW-1:0]      row, slice, base;
  logic [62:0]        prod_i;
  logic [61:0]        prod_w;
  logic [30:0]        n_m1;
  logic [IW+30:0]     ic;

  always_comb begin
    case (cmd.axis)
      dftq_pkg::AXIS_X: begin q_sel = qx; org_sel = org_x; n_sel = nx; end
      dftq_pkg::AXIS_Y: begin q_sel = qy; org_sel = org_y; n_sel = ny; end
      default:          begin q_sel = qz; org_sel = org_z; n_sel = nz; end
    endcase
  end

  assign prod_i = d[31:0] * inv;
  assign n_m1   = 31'(n_sel) - 31'd1;
  assign i_cl   = (i_raw > n_m1) ? IW'(n_m1) : IW'(i_raw);
  assign ic     = i_cl * cs;
  assign prod_w = frac[30:0] * inv;

  always_comb begin
    if (frac <= 0) begin
      t_new = '0;
    end else if (frac >= $signed(FW'(cs))) begin
      t_new = dftq_pkg::ONE_Q16;
    end else if (prod_w[61:16] > 46'(dftq_pkg::ONE_Q16)) begin
      t_new = dftq_pkg::ONE_Q16;
    end else begin
      t_new = prod_w[16 +: dftq_pkg::T_W];
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      dftq_pkg::OP_CAPTURE: begin
        qx    <= query_x;
        qy    <= query_y;
        qz    <= query_z;
        row   <= AW'(nx) + AW'(1);
        slice <= AW'((AW'(nx) + AW'(1)) * (AW'(ny) + AW'(1)));
      end
      dftq_pkg::OP_LOC_D: begin
        d   <= {q_sel[31], q_sel} - {org_sel[31], org_sel};
        top <= n_sel * cs;
      end
      dftq_pkg::OP_LOC_I: begin
        i_raw  <= prod_i[62:32];
        ax_out <= d[32] || (TOPW'(d[31:0]) > top);
      end
      dftq_pkg::OP_LOC_F: begin
        frac <= $signed(FW'(d[31:0])) - $signed(FW'(ic));
        case (cmd.axis)
          dftq_pkg::AXIS_X: ix <= i_cl;
          dftq_pkg::AXIS_Y: iy <= i_cl;
          default:          iz <= i_cl;
        endcase
      end
      dftq_pkg::OP_LOC_W: begin
        case (cmd.axis)
          dftq_pkg::AXIS_X: tx <= t_new;
          dftq_pkg::AXIS_Y: ty <= t_new;
          default:          tz <= t_new;
        endcase
      end
      dftq_pkg::OP_ADDR: begin
        base <= AW'(iz * slice + iy * row + AW'(ix));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_acc <= 1'b0;
    end else if (cmd.op == dftq_pkg::OP_CAPTURE) begin
      inside_acc <= 1'b1;
    end else if (cmd.op == dftq_pkg::OP_LOC_W && ax_out) begin
      inside_acc <= 1'b0;
    end
  end

  assign status.in_box = inside_acc;

  // Vertex store, all four channels in one word.
  logic [4*VW-1:0] mem [DEPTH];
  logic [4*VW-1:0] rd_data;
  logic [AW-1:0]   rd_addr;
  logic [2:0]      k;

  assign k = cmd.cnt[2:0];
  assign rd_addr = base + (k[2] ? slice : AW'(0)) + (k[1] ? row : AW'(0))
                 + AW'(k[0] ^ k[1]);

  always_ff @(posedge clk) begin
    if (cmd.op == dftq_pkg::OP_WRITE && 32'(vertex_index) < DEPTH) begin
      mem[AW'(vertex_index)] <= {vertex_cp_z, vertex_cp_y, vertex_cp_x, vertex_distance};
    end
    if (cmd.op == dftq_pkg::OP_READ && !cmd.cnt[3]) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Corner registers and four lerp units, one per channel.
  logic signed [VW-1:0] vtx [4][8];
  logic signed [VW-1:0] lerp_res [4];
  logic [dftq_pkg::T_W-1:0] t_sel;
  logic [2:0] a_idx, b_idx, dst_idx, cap_idx;

  assign a_idx   = dftq_pkg::lerp_a(k);
  assign b_idx   = dftq_pkg::lerp_b(k);
  assign dst_idx = dftq_pkg::lerp_dst(k);
  assign cap_idx = 3'(cmd.cnt - 4'd1);
  assign t_sel   = (k < 3'd4) ? tx : ((k < 3'd6) ? ty : tz);

  for (genvar ch = 0; ch < 4; ch++) begin : g_lerp
    logic signed [VW:0]   diff;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] sum;
    assign diff = {vtx[ch][b_idx][VW-1], vtx[ch][b_idx]}
                - {vtx[ch][a_idx][VW-1], vtx[ch][a_idx]};
    assign prod = diff * $signed({1'b0, t_sel});
    assign sum  = ($signed(PW'(vtx[ch][a_idx])) <<< dftq_pkg::FRAC_SH) + prod
                + $signed(PW'(32768));
    assign lerp_res[ch] = sum[dftq_pkg::FRAC_SH +: VW];
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 4; ch++) begin
      if (cmd.op == dftq_pkg::OP_READ && cmd.cnt != 4'd0) begin
        vtx[ch][cap_idx] <= rd_data[ch*VW +: VW];
      end else if (cmd.op == dftq_pkg::OP_LERP) begin
        vtx[ch][dst_idx] <= lerp_res[ch];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == dftq_pkg::OP_OUT) begin
      inside_res <= inside_acc;
      if (inside_acc) begin
        distance_out <= vtx[0][0];
        cp_out_x     <= vtx[1][0];
        cp_out_y     <= vtx[2][0];
        cp_out_z     <= vtx[3][0];
      end else begin
        distance_out <= {1'b0, {(VW-1){1'b1}}};
        cp_out_x     <= '0;
        cp_out_y     <= '0;
        cp_out_z     <= '0;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/distance_field_trilinear_query_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Trilinear distance-field lookup over a grid of up to MAX_CELLS cells per axis. A write
// (tuser 0) stores one vertex and returns nothing. A query (tuser 1) returns one result;
// when the point is outside the box the corner fetch and lerp steps are skipped. No new
// item is taken until the result of a query is registered. The query path is built from
// one shared per-axis locate unit (four steps per axis) and the single read port of the
// vertex store, which fetches the eight corners one per cycle, followed by seven chained
// lerp steps. Configuration writes are taken at any time but must only be issued while
// the block is idle. Store entries are undefined until written.
module distance_field_trilinear_query_top #(
  parameter int MAX_CELLS   = dftq_pkg::MAX_CELLS_DEF,
  parameter int VALUE_WIDTH = dftq_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // vertex_index, vertex_distance, vertex_cp_x, vertex_cp_y, vertex_cp_z,
  // query_x, query_y, query_z
  input  wire logic [((dftq_pkg::INDEX_W + 4*VALUE_WIDTH + 3*dftq_pkg::COORD_W + 7) / 8) * 8 - 1:0]
                    s_axis_tdata,
  // req_type
  input  wire logic s_axis_tuser,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // distance_out, cp_out_x, cp_out_y, cp_out_z
  output logic [((4*VALUE_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // inside_res
  output logic      m_axis_tuser,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic [dftq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dftq_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int VW   = VALUE_WIDTH;
  localparam int OUTW = ((4*VW + 7) / 8) * 8;
  localparam int OQ   = dftq_pkg::INDEX_W + 4*VW;

  dftq_pkg::cmd_t    cmd;
  dftq_pkg::status_t status;
  logic signed [VW-1:0] distance_out, cp_out_x, cp_out_y, cp_out_z;

  assign cfg_ready = 1'b1;

  dftq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .req_type  (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  dftq_dp #(
    .MAX_CELLS   (MAX_CELLS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .vertex_index    (s_axis_tdata[dftq_pkg::INDEX_W-1:0]),
    .vertex_distance (s_axis_tdata[dftq_pkg::INDEX_W +: VW]),
    .vertex_cp_x     (s_axis_tdata[dftq_pkg::INDEX_W + VW +: VW]),
    .vertex_cp_y     (s_axis_tdata[dftq_pkg::INDEX_W + 2*VW +: VW]),
    .vertex_cp_z     (s_axis_tdata[dftq_pkg::INDEX_W + 3*VW +: VW]),
    .query_x         (s_axis_tdata[OQ +: dftq_pkg::COORD_W]),
    .query_y         (s_axis_tdata[OQ + dftq_pkg::COORD_W +: dftq_pkg::COORD_W]),
    .query_z         (s_axis_tdata[OQ + 2*dftq_pkg::COORD_W +: dftq_pkg::COORD_W]),
    .inside_res      (m_axis_tuser),
    .distance_out    (distance_out),
    .cp_out_x        (cp_out_x),
    .cp_out_y        (cp_out_y),
    .cp_out_z        (cp_out_z)
  );

  assign m_axis_tdata = OUTW'({cp_out_z, cp_out_y, cp_out_x, distance_out});

endmodule
`default_nettype wire
